FILE: rtl/chst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chst_pkg;

  localparam int MAX_SEGMENTS      = 32;
  localparam int COS_TABLE_ENTRIES = 1024;

  localparam int X_W     = 23;
  localparam int Y_W     = 16;
  localparam int W_W     = 13;
  localparam int SEGI_W  = 5;
  localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W   = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int COS_W   = 17;

  localparam int DIV_N_W = 23;
  localparam int DIV_D_W = 13;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [W_W-1:0] SEG_WIDTH_RESET = 13'd160;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic signed [COS_W-1:0] cos_t;
  typedef cos_t cos_table_t [0:COS_TABLE_ENTRIES];

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } div_rsp_t;

  // round(32768*cos(theta)), theta in Q30 over the first quarter period
  function automatic cos_t cos_quarter_q15(input logic [63:0] theta);
    logic [63:0] x2;
    logic [63:0] mag;
    longint      sum;
    int          n;
    x2  = (theta * theta) >> 30;
    mag = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    for (n = 1; n <= 8; n++) begin
      mag = (mag * x2) >> 30;
      case (n)
        1:       mag = mag / 64'd2;
        2:       mag = mag / 64'd12;
        3:       mag = mag / 64'd30;
        4:       mag = mag / 64'd56;
        5:       mag = mag / 64'd90;
        6:       mag = mag / 64'd132;
        7:       mag = mag / 64'd182;
        default: mag = mag / 64'd240;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return cos_t'((64'(sum) + (64'd1 << 14)) >> 15);
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t t;
    int         k;
    for (k = 0; k <= COS_TABLE_ENTRIES; k++) begin
      if (2 * k <= COS_TABLE_ENTRIES) begin
        t[k] = cos_quarter_q15(PI_Q30 * 64'(k) / COS_TABLE_ENTRIES);
      end else begin
        t[k] = -cos_quarter_q15(PI_Q30 * 64'(COS_TABLE_ENTRIES - k) / COS_TABLE_ENTRIES);
      end
    end
    return t;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage
`default_nettype wire

FILE: rtl/cosine_hill_segment_tessellator_top.sv
// Each accepted key point runs three 23-step divisions on the shared divider, then
//   one pass through S_STEP, S_ROM, S_MUL, S_SUM and S_OUT per segment, held by out_ready.
// A new key point is taken only once the last segment of its span is accepted;
//   a restart or first point is only stored. in_ready is low while a span is in work.
// Reset (rst, synchronous, active high): no point stored, segment_width = 160,
//   no beat pending.
`timescale 1ns / 1ps
`default_nettype none
module cosine_hill_segment_tessellator_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire [chst_pkg::W_W-1:0]           cfg_wr_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire signed [chst_pkg::X_W-1:0]    point_x,
  input  wire [chst_pkg::Y_W-1:0]           point_y,
  input  wire                               restart,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [chst_pkg::X_W-1:0]   seg_start_x,
  output logic [chst_pkg::Y_W-1:0]          seg_start_y,
  output logic signed [chst_pkg::X_W-1:0]   seg_end_x,
  output logic [chst_pkg::Y_W-1:0]          seg_end_y,
  output logic [chst_pkg::SEGI_W-1:0]       seg_index,
  output logic                              last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVW = 4'd1;
  localparam logic [3:0] S_DIVX = 4'd2;
  localparam logic [3:0] S_DIVI = 4'd3;
  localparam logic [3:0] S_STEP = 4'd4;
  localparam logic [3:0] S_ROM  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int CW = chst_pkg::COUNT_W;
  localparam int XW = chst_pkg::X_W;
  localparam int YW = chst_pkg::Y_W;
  localparam int IW = chst_pkg::IDX_W;

  logic [3:0]                     state;
  logic [chst_pkg::W_W-1:0]       seg_w;
  logic signed [XW-1:0]           prev_x;
  logic [YW-1:0]                  prev_y;
  logic                           prev_valid;
  logic signed [XW-1:0]           x1;
  logic [YW-1:0]                  y1;
  logic                           span_neg;
  logic [XW-1:0]                  span_mag;
  logic [CW-1:0]                  count;
  logic [XW-1:0]                  q_step;
  logic [CW-1:0]                  r_step;
  logic [IW-1:0]                  qi_step;
  logic [CW:0]                    ri_step;
  logic [XW-1:0]                  qx;
  logic [CW-1:0]                  rx;
  logic [IW-1:0]                  qi;
  logic [CW:0]                    ri;
  logic [CW-1:0]                  k;
  logic signed [33:0]             prod;

  logic                           div_start;
  logic [chst_pkg::DIV_N_W-1:0]   div_dividend;
  logic [chst_pkg::DIV_D_W-1:0]   div_divisor;
  chst_pkg::div_req_t             div_req;
  chst_pkg::div_rsp_t             div_rsp;
  chst_pkg::cos_t                 rom_data;

  logic signed [XW:0]             span;
  logic [chst_pkg::W_W-1:0]       w_eff;
  logic [CW-1:0]                  cnt_sat;
  logic [CW:0]                    rx_sum;
  logic [CW+1:0]                  ri_sum;
  logic                           rx_wrap;
  logic                           ri_wrap;
  logic signed [XW:0]             x_off;
  logic signed [XW:0]             end_x_full;
  logic signed [YW:0]             dy;
  logic [YW:0]                    ysum;
  logic signed [34:0]             total;
  logic [34:0]                    rnd;
  logic [18:0]                    y_full;
  logic [YW-1:0]                  end_y;

  assign in_ready = (state == S_IDLE);

  assign div_req = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  always_comb begin
    span  = $signed({point_x[XW-1], point_x}) - $signed({prev_x[XW-1], prev_x});
    w_eff = (seg_w == '0) ? chst_pkg::W_W'(1) : seg_w;

    if (div_rsp.quotient == '0) begin
      cnt_sat = CW'(1);
    end else if (div_rsp.quotient > chst_pkg::DIV_N_W'(chst_pkg::MAX_SEGMENTS)) begin
      cnt_sat = CW'(chst_pkg::MAX_SEGMENTS);
    end else begin
      cnt_sat = div_rsp.quotient[CW-1:0];
    end

    rx_sum  = {1'b0, rx} + {1'b0, r_step};
    rx_wrap = rx_sum >= {1'b0, count};
    ri_sum  = {1'b0, ri} + {1'b0, ri_step};
    ri_wrap = ri_sum >= {1'b0, count, 1'b0};

    x_off      = span_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    end_x_full = $signed({prev_x[XW-1], prev_x}) + x_off;

    dy    = $signed({1'b0, prev_y}) - $signed({1'b0, y1});
    ysum  = {1'b0, prev_y} + {1'b0, y1};
    total = $signed({2'b00, ysum, 15'd0}) + 35'(prod);
    rnd   = (total < 0) ? 35'd32768 : 35'(total) + 35'd32768;
    y_full = rnd[34:16];
    end_y  = (y_full > 19'(16'hFFFF)) ? 16'hFFFF : y_full[YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg_w         <= chst_pkg::SEG_WIDTH_RESET;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_valid    <= 1'b0;
      out_valid     <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_wr_en) begin
        seg_w <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart || !prev_valid) begin
              prev_x     <= point_x;
              prev_y     <= point_y;
              prev_valid <= 1'b1;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIVW;
            end
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            div_start <= 1'b1;
            state     <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            div_start <= 1'b1;
            state     <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (div_rsp.done) begin
            state <= S_STEP;
          end
        end
        S_STEP: state <= S_ROM;
        S_ROM:  state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              prev_x <= x1;
              prev_y <= y1;
              state  <= S_IDLE;
            end else begin
              state <= S_STEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: divider operands, grid accumulators and the output beat
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x1       <= point_x;
        y1       <= point_y;
        span_neg <= span[XW];
        span_mag <= span[XW] ? XW'(-span) : span[XW-1:0];
        div_dividend <= span[XW] ? '0 : span[XW-1:0];
        div_divisor  <= w_eff;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          count        <= cnt_sat;
          div_dividend <= span_mag;
          div_divisor  <= chst_pkg::DIV_D_W'(cnt_sat);
        end
      end
      S_DIVX: begin
        if (div_rsp.done) begin
          q_step       <= div_rsp.quotient;
          r_step       <= div_rsp.remainder[CW-1:0];
          div_dividend <= chst_pkg::DIV_N_W'(chst_pkg::COS_TABLE_ENTRIES);
        end
      end
      S_DIVI: begin
        if (div_rsp.done) begin
          qi_step     <= div_rsp.quotient[IW-1:0];
          ri_step     <= {div_rsp.remainder[CW-1:0], 1'b0};
          qx          <= '0;
          rx          <= '0;
          qi          <= '0;
          ri          <= {1'b0, count};
          k           <= '0;
          seg_start_x <= prev_x;
          seg_start_y <= prev_y;
        end
      end
      S_STEP: begin
        // advance to grid point k+1
        qx <= qx + q_step + XW'(rx_wrap);
        rx <= rx_wrap ? CW'(rx_sum - {1'b0, count}) : rx_sum[CW-1:0];
        qi <= qi + qi_step + IW'(ri_wrap);
        ri <= ri_wrap ? (CW+1)'(ri_sum - {1'b0, count, 1'b0}) : ri_sum[CW:0];
      end
      S_MUL: begin
        prod <= dy * rom_data;
      end
      S_SUM: begin
        seg_end_x <= end_x_full[XW-1:0];
        seg_end_y <= end_y;
        seg_index <= k[chst_pkg::SEGI_W-1:0];
        last      <= (k + 1'b1) == count;
      end
      S_OUT: begin
        if (out_ready) begin
          seg_start_x <= seg_end_x;
          seg_start_y <= seg_end_y;
          k           <= k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  chst_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  chst_cos_rom u_rom (
    .clk  (clk),
    .addr (qi),
    .data (rom_data)
  );

endmodule
`default_nettype wire

FILE: rtl/chst_div.sv
`timescale 1ns / 1ps
`default_nettype none
module chst_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire chst_pkg::div_req_t req,
  output chst_pkg::div_rsp_t  rsp
);

  logic                              busy;
  logic                              done;
  logic [chst_pkg::DIV_CNT_W-1:0]    cnt;
  logic [chst_pkg::DIV_D_W-1:0]      rem;
  logic [chst_pkg::DIV_N_W-1:0]      quo;
  logic [chst_pkg::DIV_D_W-1:0]      dvsr;

  logic [chst_pkg::DIV_D_W:0]        trial;
  logic                              ge;
  logic [chst_pkg::DIV_D_W-1:0]      rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, quo[chst_pkg::DIV_N_W-1]};
    ge       = trial >= {1'b0, dvsr};
    rem_next = ge ? chst_pkg::DIV_D_W'(trial - {1'b0, dvsr})
                  : trial[chst_pkg::DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == chst_pkg::DIV_CNT_W'(chst_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[chst_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

FILE: rtl/chst_cos_rom.sv
`timescale 1ns / 1ps
`default_nettype none
module chst_cos_rom (
  input  wire                           clk,
  input  wire [chst_pkg::IDX_W-1:0]     addr,
  output chst_pkg::cos_t                data
);

  always_ff @(posedge clk) begin
    data <= chst_pkg::COS_TABLE[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/chst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module chst_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire signed [chst_pkg::X_W-1:0]    seg_start_x,
  input wire [chst_pkg::Y_W-1:0]           seg_start_y,
  input wire signed [chst_pkg::X_W-1:0]    seg_end_x,
  input wire [chst_pkg::Y_W-1:0]           seg_end_y,
  input wire [chst_pkg::SEGI_W-1:0]        seg_index,
  input wire                               last
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_start_x) && $stable(seg_start_y)
      && $stable(seg_end_x) && $stable(seg_end_y) && $stable(seg_index) && $stable(last))
    else $error("stalled output beat changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a segment beat is pending");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("not ready after final segment of span");

  a_span_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("ready before span finished");

endmodule

bind cosine_hill_segment_tessellator_top chst_checker u_chst_checker (.*);
`default_nettype wire

FILE: dv/cosine_hill_segment_tessellator_top_tb.sv
`timescale 1ns / 1ps
module cosine_hill_segment_tessellator_top_tb;

  typedef longint unsigned u64_t;
  typedef logic signed [chst_pkg::X_W-1:0] xcoord_t;
  typedef logic [chst_pkg::Y_W-1:0] ycoord_t;

  typedef struct packed {
    xcoord_t x;
    ycoord_t y;
    logic    restart;
  } key_point_t;

  typedef struct packed {
    xcoord_t                     start_x;
    ycoord_t                     start_y;
    xcoord_t                     end_x;
    ycoord_t                     end_y;
    logic [chst_pkg::SEGI_W-1:0] index;
    logic                        last;
  } segment_t;

  localparam int          CYCLE_LIMIT   = 1500000;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          HOLD_CYCLES   = 500;
  localparam logic [chst_pkg::W_W-1:0] WIDTH_AT_RESET = 13'd160;
  localparam u64_t        PI_Q30_TB     = 64'd3373259426;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [chst_pkg::W_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  xcoord_t point_x = '0;
  ycoord_t point_y = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  xcoord_t seg_start_x;
  ycoord_t seg_start_y;
  xcoord_t seg_end_x;
  ycoord_t seg_end_y;
  logic [chst_pkg::SEGI_W-1:0] seg_index;
  logic last;

  cosine_hill_segment_tessellator_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .seg_index   (seg_index),
    .last        (last)
  );

  always #10 clk = ~clk;

  key_point_t pending_points [$];
  segment_t   expected_segs [$];
  int         cos_lut [0:chst_pkg::COS_TABLE_ENTRIES];

  // predictor state
  logic [chst_pkg::W_W-1:0] model_width = WIDTH_AT_RESET;
  xcoord_t        model_prev_x = '0;
  ycoord_t        model_prev_y = '0;
  logic           model_have_prev = 1'b0;

  // stimulus bookkeeping
  longint gen_last_x = 0;

  int   fault_count = 0;
  int   cycle_count = 0;
  logic in_beat_taken = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_requested = 1'b0;
  bit   hold_served = 1'b0;
  bit   steady_phase = 1'b0;

  function automatic int quarter_cos_q15(u64_t theta);
    u64_t   sq;
    u64_t   term;
    longint acc;
    int     n;
    sq   = (theta * theta) >> 30;
    term = u64_t'(1) << 30;
    acc  = longint'(u64_t'(1) << 30);
    for (n = 1; n <= 8; n++) begin
      term = ((term * sq) >> 30) / u64_t'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((u64_t'(acc) + (u64_t'(1) << 14)) >> 15);
  endfunction

  // y on the half-cosine between y0 and y1 at grid point j of n
  function automatic ycoord_t hill_height(longint y0, longint y1, longint j, longint n);
    longint idx;
    longint total;
    idx   = (2 * j * chst_pkg::COS_TABLE_ENTRIES + n) / (2 * n);
    total = (y0 + y1) * 32768 + (y0 - y1) * longint'(cos_lut[idx]);
    if (total < 0) begin
      total = 0;
    end
    total = (total + 32768) >>> 16;
    if (total > 65535) begin
      total = 65535;
    end
    return ycoord_t'(total);
  endfunction

  task automatic tessellate_point(input xcoord_t px, input ycoord_t py, input logic rs);
    longint   x0;
    longint   y0;
    longint   span;
    longint   w;
    longint   n;
    longint   k;
    segment_t s;
    if (!rs && model_have_prev) begin
      x0   = model_prev_x;
      y0   = model_prev_y;
      span = longint'(px) - x0;
      w    = (model_width == 0) ? 1 : longint'(model_width);
      n    = (span < w) ? 1 : span / w;
      if (n > chst_pkg::MAX_SEGMENTS) begin
        n = chst_pkg::MAX_SEGMENTS;
      end
      for (k = 0; k < n; k++) begin
        s.start_x = xcoord_t'(x0 + (span * k) / n);
        s.start_y = hill_height(y0, py, k, n);
        s.end_x   = xcoord_t'(x0 + (span * (k + 1)) / n);
        s.end_y   = hill_height(y0, py, k + 1, n);
        s.index   = k[chst_pkg::SEGI_W-1:0];
        s.last    = (k == n - 1);
        expected_segs.insert(expected_segs.size(), s);
      end
    end
    model_prev_x    = px;
    model_prev_y    = py;
    model_have_prev = 1'b1;
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%t ERROR: %s", $realtime, msg);
    end
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_point(input longint x, input int unsigned y, input bit rs);
    key_point_t p;
    p.x       = xcoord_t'(x);
    p.y       = ycoord_t'(y);
    p.restart = rs;
    pending_points.insert(pending_points.size(), p);
    gen_last_x = longint'(p.x);
  endtask

  task automatic queue_step(input longint delta, input int unsigned y);
    queue_point(gen_last_x + delta, y, 1'b0);
  endtask

  // mostly chained spans with small counts; some long, saturating, backward,
  // full-range and restart points mixed in
  task automatic queue_random_points(input int count, input longint w);
    int     i;
    int     r;
    longint nx;
    bit     rs;
    int unsigned ny;
    for (i = 0; i < count; i++) begin
      r  = $urandom_range(0, 99);
      rs = 1'b0;
      ny = $urandom_range(0, 65535);
      if (r < 50) begin
        nx = gen_last_x + $urandom_range(0, 7 * w - 1);
      end else if (r < 62) begin
        nx = gen_last_x + $urandom_range(6 * w, 32 * w - 1);
      end else if (r < 68) begin
        nx = gen_last_x + $urandom_range(32 * w, 64 * w);
      end else if (r < 76) begin
        nx = gen_last_x - $urandom_range(0, 4 * w);
      end else if (r < 82) begin
        nx = longint'(xcoord_t'($urandom));
      end else if (r < 92) begin
        nx = longint'(xcoord_t'($urandom));
        rs = 1'b1;
      end else begin
        nx = gen_last_x + $urandom_range(0, 3 * w);
        ny = ($urandom_range(0, 1) == 1) ? 65535 : 0;
      end
      if (nx > 4194303 || nx < -4194304) begin
        nx = $urandom_range(0, 200000) - 4194304;
        rs = 1'b1;
      end
      queue_point(nx, ny, rs);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_points.size() != 0 || in_valid || expected_segs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_segment_width(input logic [chst_pkg::W_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_width = value;
  endtask

  // key point driver
  always @(negedge clk) begin : drive_points
    key_point_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat_taken) begin
      // hold the beat until accepted
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_points.size() != 0) begin
      p = pending_points.pop_front();
      point_x  <= p.x;
      point_y  <= p.y;
      restart  <= p.restart;
      in_valid <= 1'b1;
      gap_left = sender_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // segment receiver
  always @(negedge clk) begin : drive_ready
    int r;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_requested && !hold_served) begin
      hold_served = 1'b1;
      hold_left   = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (steady_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 40);
      end
    end
  end

  // scoreboard: check segment beats, then predict from accepted key points
  always @(posedge clk) begin : check_segments
    segment_t e;
    if (rst) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          report_fault($sformatf("unexpected segment x %0d..%0d y %0d..%0d idx %0d last %0b",
                                 seg_start_x, seg_end_x, seg_start_y, seg_end_y,
                                 seg_index, last));
        end else begin
          e = expected_segs.pop_front();
          if (seg_start_x !== e.start_x || seg_start_y !== e.start_y ||
              seg_end_x !== e.end_x || seg_end_y !== e.end_y ||
              seg_index !== e.index || last !== e.last) begin
            report_fault($sformatf(
              "segment mismatch exp x %0d..%0d y %0d..%0d idx %0d last %0b, got x %0d..%0d y %0d..%0d idx %0d last %0b",
              e.start_x, e.end_x, e.start_y, e.end_y, e.index, e.last,
              seg_start_x, seg_end_x, seg_start_y, seg_end_y, seg_index, last));
          end
        end
      end
      if (in_valid && in_ready) begin
        tessellate_point(point_x, point_y, restart);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cosine_hill_segment_tessellator_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int k;
    int unsigned w;
    for (k = 0; k <= chst_pkg::COS_TABLE_ENTRIES; k++) begin
      if (2 * k <= chst_pkg::COS_TABLE_ENTRIES) begin
        cos_lut[k] = quarter_cos_q15(PI_Q30_TB * u64_t'(k) / chst_pkg::COS_TABLE_ENTRIES);
      end else begin
        cos_lut[k] = -quarter_cos_q15(PI_Q30_TB * u64_t'(chst_pkg::COS_TABLE_ENTRIES - k) /
                                      chst_pkg::COS_TABLE_ENTRIES);
      end
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed points at the reset width
    queue_point(0, 0, 1'b0);                    // first point is only stored
    queue_step(5 * 160, 65535);                 // five segments, y bottom to top
    queue_step(0, 0);                           // zero span
    queue_step(-100, 1000);                     // backward span
    queue_point(-4194304, 16'h5555, 1'b1);
    queue_point(4194303, 16'hAAAA, 1'b0);       // full x range, count saturates
    queue_step(0, 16'hAAAA);
    queue_point(-100, 12345, 1'b1);
    queue_step(159, 200);                       // just under one width
    queue_step(160, 200);                       // exactly one width, flat
    queue_step(320, 65535);
    queue_point(1000, 1, 1'b1);
    queue_point(2000, 2, 1'b1);                 // restart right after restart
    queue_step(31 * 160 + 159, 0);
    queue_step(32 * 160, 40000);
    queue_step(33 * 160 + 5, 0);                // one over the bound
    queue_point(-4194304, 65535, 1'b1);
    queue_step(1000, 0);
    queue_random_points(40, 160);
    wait_idle();

    write_segment_width(13'd0);                 // acts as a width of one
    queue_random_points(20, 1);
    wait_idle();

    write_segment_width(13'd16);
    queue_random_points(30, 16);
    wait_idle();

    write_segment_width(13'd4096);
    queue_random_points(30, 4096);
    wait_idle();

    steady_phase = 1'b1;
    write_segment_width(13'h1FFF);
    queue_random_points(25, 8191);
    wait_idle();
    steady_phase = 1'b0;

    w = $urandom_range(1, 300);
    write_segment_width(w[chst_pkg::W_W-1:0]);
    queue_random_points(40, w);
    hold_requested = 1'b1;                      // receiver blocks while points keep coming
    wait_idle();

    if (fault_count == 0 && expected_segs.size() == 0) begin
      $display("cosine_hill_segment_tessellator_top_tb: done, clean");
    end else begin
      $display("cosine_hill_segment_tessellator_top_tb: done, errors");
    end
    $finish;
  end

endmodule
